// ===== rtl/table_interpolated_sine_top_assert.svh =====
// Assertion macros shared by the table interpolated sine RTL.
`ifndef TABLE_INTERPOLATED_SINE_TOP_ASSERT_SVH
`define TABLE_INTERPOLATED_SINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TIS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TIS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tis_pkg.sv =====
// Types and constants of the table interpolated sine evaluator.
package tis_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;

  localparam int ANGLE_W  = 10;
  localparam int STEP_W   = 9;
  localparam int IDX_W    = 5;
  localparam int SAMPLE_W = 16;
  localparam int OFS_W    = 10;
  localparam int PROD_W   = SAMPLE_W + STEP_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic signed [ANGLE_W-1:0] LOW_ANGLE_RST  = 10'sd0;
  localparam logic signed [ANGLE_W-1:0] HIGH_ANGLE_RST = 10'sd90;
  localparam logic [STEP_W-1:0]         STEP_SIZE_RST  = 9'd5;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_BELOW = 2'd1,
    ERR_ABOVE = 2'd2,
    ERR_DEPTH = 2'd3
  } range_err_e;

  typedef enum logic [1:0] {
    REG_LOW_ANGLE  = 2'd0,
    REG_HIGH_ANGLE = 2'd1,
    REG_STEP_SIZE  = 2'd2
  } cfg_reg_e;

  // sideband through the index divider
  typedef struct packed {
    action_e                     action;
    range_err_e                  err;
    logic [IDX_W-1:0]            idx;
    logic signed [SAMPLE_W-1:0]  val;
  } pre_side_t;

  // request into the table stage
  typedef struct packed {
    action_e                     action;
    range_err_e                  err;
    logic [IDX_W-1:0]            idx;
    logic signed [SAMPLE_W-1:0]  val;
    logic [OFS_W-1:0]            quot;
    logic [STEP_W-1:0]           rem;
    logic [STEP_W-1:0]           step;
  } tbl_req_t;

  // neighbour samples out of the table stage
  typedef struct packed {
    range_err_e                  err;
    logic signed [SAMPLE_W-1:0]  lower;
    logic signed [SAMPLE_W-1:0]  upper;
    logic [STEP_W-1:0]           rem;
    logic [STEP_W-1:0]           step;
  } tbl_rsp_t;

  // sideband through the fraction divider
  typedef struct packed {
    range_err_e                  err;
    logic signed [SAMPLE_W-1:0]  lower;
    logic                        neg;
  } mix_side_t;

endpackage

// ===== rtl/tis_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`include "table_interpolated_sine_top_assert.svh"

module tis_div #(
  parameter int  Q_W = 10,
  parameter int  D_W = 9,
  parameter type side_t = logic
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [Q_W-1:0] dividend_i,
  input  logic [D_W-1:0] rem_i,
  input  logic [D_W-1:0] divisor_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [Q_W-1:0] quot_o,
  output logic [D_W-1:0] rem_o,
  output logic [D_W-1:0] divisor_o,
  output side_t          side_o
);

  logic [Q_W-1:0] valid_q;
  logic [Q_W-1:0] num_q [Q_W];
  logic [D_W-1:0] rem_q [Q_W];
  logic [D_W-1:0] div_q [Q_W];
  side_t          side_q [Q_W];

  logic [Q_W-1:0] num_d [Q_W];
  logic [D_W-1:0] rem_d [Q_W];

  logic [Q_W:0]   valid_s;
  logic [Q_W-1:0] num_s [Q_W+1];
  logic [D_W-1:0] rem_s [Q_W+1];
  logic [D_W-1:0] div_s [Q_W+1];
  side_t          side_s [Q_W+1];

  always_comb begin
    valid_s[0] = valid_i;
    num_s[0]   = dividend_i;
    rem_s[0]   = rem_i;
    div_s[0]   = divisor_i;
    side_s[0]  = side_i;
    for (int s = 0; s < Q_W; s++) begin
      valid_s[s+1] = valid_q[s];
      num_s[s+1]   = num_q[s];
      rem_s[s+1]   = rem_q[s];
      div_s[s+1]   = div_q[s];
      side_s[s+1]  = side_q[s];
    end
  end

  always_comb begin
    logic [D_W:0] trial;
    for (int s = 0; s < Q_W; s++) begin
      trial = {rem_s[s], num_s[s][Q_W-1]};
      if (trial >= {1'b0, div_s[s]}) begin
        rem_d[s] = D_W'(trial - {1'b0, div_s[s]});
        num_d[s] = {num_s[s][Q_W-2:0], 1'b1};
      end else begin
        rem_d[s] = trial[D_W-1:0];
        num_d[s] = {num_s[s][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_s[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Q_W; s++) begin
      num_q[s]  <= num_d[s];
      rem_q[s]  <= rem_d[s];
      div_q[s]  <= div_s[s];
      side_q[s] <= side_s[s];
    end
  end

  assign valid_o   = valid_s[Q_W];
  assign quot_o    = num_s[Q_W];
  assign rem_o     = rem_s[Q_W];
  assign divisor_o = div_s[Q_W];
  assign side_o    = side_s[Q_W];

  `TIS_ASSERT_NOW(a_div_in_rem, valid_i, rem_i < divisor_i, "divider: initial remainder too big")
  `TIS_ASSERT_NOW(a_div_out_rem, valid_o, rem_o < divisor_o, "divider: remainder not reduced")
  `TIS_ASSERT_NOW(a_div_nonzero, valid_o, divisor_o != '0, "divider: zero divisor")

endmodule

// ===== rtl/tis_table.sv =====
// Sample table stage: index check, sample write, two-neighbour registered read.
module tis_table
  import tis_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  tbl_req_t req_i,
  output logic     valid_o,
  output tbl_rsp_t rsp_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [SAMPLE_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] lower_q, upper_q;
  logic                valid_q;
  range_err_e          err_q, err_d;
  logic [STEP_W-1:0]   rem_q, step_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr, lo_addr, hi_addr;
  logic          quot_ok, up_ok;

  assign wr_en   = valid_i && (req_i.action == ACT_WRITE) && (int'(req_i.idx) < TABLE_DEPTH);
  assign wr_addr = AW'(req_i.idx);
  assign lo_addr = AW'(req_i.quot);
  assign hi_addr = AW'({1'b0, req_i.quot} + 11'd1);
  assign quot_ok = int'(req_i.quot) < TABLE_DEPTH;
  assign up_ok   = (int'(req_i.quot) + 1) < TABLE_DEPTH;

  always_comb begin
    err_d = req_i.err;
    if (req_i.err == ERR_NONE) begin
      if (!quot_ok || ((req_i.rem != '0) && !up_ok)) begin
        err_d = ERR_DEPTH;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_i.val;
    end
    lower_q <= mem_q[lo_addr];
    upper_q <= mem_q[hi_addr];
    err_q   <= err_d;
    rem_q   <= req_i.rem;
    step_q  <= req_i.step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i && (req_i.action == ACT_EVAL);
    end
  end

  assign valid_o     = valid_q;
  assign rsp_o.err   = err_q;
  assign rsp_o.lower = lower_q;
  assign rsp_o.upper = upper_q;
  assign rsp_o.rem   = rem_q;
  assign rsp_o.step  = step_q;

endmodule

// ===== rtl/table_interpolated_sine_top.sv =====
// Table interpolated sine evaluator: config port, range check, index and fraction pipelines.
// Throughput: one transaction per cycle; busy stays low, writes take the same path as far as the table.
// Depth is set by two one-bit-per-stage dividers (10 and 16 stages) plus 4 other stages.
// Reset clears config to low 0, high 90, step 5 and all pipeline valids; the table
// holds undefined samples until written.
`include "table_interpolated_sine_top_assert.svh"

module table_interpolated_sine_top
  import tis_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic signed [ANGLE_W-1:0]  angle_i,
  input  logic [IDX_W-1:0]           entry_index_i,
  input  logic signed [SAMPLE_W-1:0] entry_value_i,
  output logic                       result_valid_o,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic [1:0]                 range_error_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  // configuration registers
  logic signed [ANGLE_W-1:0] low_q, high_q;
  logic [STEP_W-1:0]         step_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_ANGLE_RST;
      high_q <= HIGH_ANGLE_RST;
      step_q <= STEP_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOW_ANGLE:  low_q  <= pwdata[ANGLE_W-1:0];
        REG_HIGH_ANGLE: high_q <= pwdata[ANGLE_W-1:0];
        REG_STEP_SIZE:  step_q <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOW_ANGLE:  prdata = DATA_W'(low_q);
      REG_HIGH_ANGLE: prdata = DATA_W'(high_q);
      REG_STEP_SIZE:  prdata = DATA_W'(step_q);
      default:        prdata = '0;
    endcase
  end

  // stage 0: bound check and offset
  logic              acc;
  logic              s0_valid_q;
  pre_side_t         s0_side_q, s0_side_d;
  logic [OFS_W-1:0]  s0_ofs_q, s0_ofs_d;
  logic [STEP_W-1:0] s0_step_q, s0_step_d;
  logic [ANGLE_W:0]  ofs_full;

  assign acc      = start && !busy;
  assign ofs_full = {angle_i[ANGLE_W-1], angle_i} - {low_q[ANGLE_W-1], low_q};

  always_comb begin
    s0_side_d.action = action_e'(action_i);
    s0_side_d.idx    = entry_index_i;
    s0_side_d.val    = entry_value_i;
    if (angle_i < low_q) begin
      s0_side_d.err = ERR_BELOW;
    end else if (angle_i > high_q) begin
      s0_side_d.err = ERR_ABOVE;
    end else begin
      s0_side_d.err = ERR_NONE;
    end
    s0_ofs_d  = ofs_full[OFS_W-1:0];
    s0_step_d = (step_q == '0) ? STEP_W'(1) : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_ofs_q  <= s0_ofs_d;
    s0_step_q <= s0_step_d;
  end

  // index divider: offset / step
  logic              d1_valid;
  logic [OFS_W-1:0]  d1_quot;
  logic [STEP_W-1:0] d1_rem, d1_step;
  pre_side_t         d1_side;

  tis_div #(
    .Q_W    (OFS_W),
    .D_W    (STEP_W),
    .side_t (pre_side_t)
  ) u_idx_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s0_valid_q),
    .dividend_i (s0_ofs_q),
    .rem_i      ('0),
    .divisor_i  (s0_step_q),
    .side_i     (s0_side_q),
    .valid_o    (d1_valid),
    .quot_o     (d1_quot),
    .rem_o      (d1_rem),
    .divisor_o  (d1_step),
    .side_o     (d1_side)
  );

  // table stage
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;
  logic     tbl_valid;

  always_comb begin
    tbl_req.action = d1_side.action;
    tbl_req.err    = d1_side.err;
    tbl_req.idx    = d1_side.idx;
    tbl_req.val    = d1_side.val;
    tbl_req.quot   = d1_quot;
    tbl_req.rem    = d1_rem;
    tbl_req.step   = d1_step;
  end

  tis_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_valid),
    .req_i   (tbl_req),
    .valid_o (tbl_valid),
    .rsp_o   (tbl_rsp)
  );

  // multiply stage: |upper - lower| * rem
  logic signed [SAMPLE_W:0] delta;
  logic [SAMPLE_W-1:0]      delta_mag;
  logic                     mul_valid_q;
  logic [PROD_W-1:0]        mul_prod_q, mul_prod_d;
  mix_side_t                mul_side_q, mul_side_d;
  logic [STEP_W-1:0]        mul_step_q;

  assign delta     = {tbl_rsp.upper[SAMPLE_W-1], tbl_rsp.upper}
                   - {tbl_rsp.lower[SAMPLE_W-1], tbl_rsp.lower};
  assign delta_mag = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : delta[SAMPLE_W-1:0];
  assign mul_prod_d = PROD_W'(delta_mag) * PROD_W'(tbl_rsp.rem);

  always_comb begin
    mul_side_d.err   = tbl_rsp.err;
    mul_side_d.lower = tbl_rsp.lower;
    mul_side_d.neg   = delta[SAMPLE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= tbl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_prod_q <= mul_prod_d;
    mul_side_q <= mul_side_d;
    mul_step_q <= tbl_rsp.step;
  end

  // fraction divider: product / step, quotient fits the sample width
  logic                d2_valid;
  logic [SAMPLE_W-1:0] d2_quot;
  mix_side_t           d2_side;

  tis_div #(
    .Q_W    (SAMPLE_W),
    .D_W    (STEP_W),
    .side_t (mix_side_t)
  ) u_frac_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mul_valid_q),
    .dividend_i (mul_prod_q[SAMPLE_W-1:0]),
    .rem_i      (mul_prod_q[PROD_W-1:SAMPLE_W]),
    .divisor_i  (mul_step_q),
    .side_i     (mul_side_q),
    .valid_o    (d2_valid),
    .quot_o     (d2_quot),
    .rem_o      (),
    .divisor_o  (),
    .side_o     (d2_side)
  );

  // output stage
  logic [SAMPLE_W:0]          frac, sum;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_value_q, out_value_d;
  range_err_e                 out_err_q;

  assign frac = d2_side.neg ? -{1'b0, d2_quot} : {1'b0, d2_quot};
  assign sum  = {d2_side.lower[SAMPLE_W-1], d2_side.lower} + frac;
  assign out_value_d = (d2_side.err == ERR_NONE) ? sum[SAMPLE_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_err_q   <= d2_side.err;
  end

  assign result_valid_o = out_valid_q;
  assign value_o        = out_value_q;
  assign range_error_o  = out_err_q;

  `TIS_ASSERT_NOW(a_err_zero, result_valid_o && (range_error_o != ERR_NONE), value_o == '0, "value not zero on range error")
  `TIS_ASSERT_NOW(a_frac_fits, mul_valid_q, mul_prod_q[PROD_W-1:SAMPLE_W] < mul_step_q, "fraction quotient overflows")
  `TIS_ASSERT_NEXT(a_write_silent, d1_valid && (d1_side.action == ACT_WRITE), !tbl_valid, "write transaction went on past the table")

endmodule

// ===== tb/table_interpolated_sine_checker.sv =====
// Checker for the table interpolated sine evaluator: mirrors config and table, predicts, compares.
module table_interpolated_sine_checker
  import tis_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       action_i,
  input  logic signed [ANGLE_W-1:0]  angle_i,
  input  logic [IDX_W-1:0]           entry_index_i,
  input  logic signed [SAMPLE_W-1:0] entry_value_i,
  input  logic                       result_valid_i,
  input  logic signed [SAMPLE_W-1:0] value_i,
  input  logic [1:0]                 range_error_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [ADDR_W-1:0]          paddr_i,
  input  logic [DATA_W-1:0]          pwdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    range_err_e                 err;
  } sine_result_t;

  logic signed [ANGLE_W-1:0]  low_angle_q  = LOW_ANGLE_RST;
  logic signed [ANGLE_W-1:0]  high_angle_q = HIGH_ANGLE_RST;
  logic [STEP_W-1:0]          step_q       = STEP_SIZE_RST;
  logic signed [SAMPLE_W-1:0] sample_mirror [DEPTH];
  sine_result_t               expected_results [$];
  sine_result_t               want;
  int                         fails = 0;

  function automatic sine_result_t interpolate_angle(logic signed [ANGLE_W-1:0] angle);
    int offset, step, quot, rem, lower, upper;
    sine_result_t r;
    r.value = '0;
    r.err   = ERR_NONE;
    if (angle < low_angle_q) begin
      r.err = ERR_BELOW;
    end else if (angle > high_angle_q) begin
      r.err = ERR_ABOVE;
    end else begin
      offset = int'(angle) - int'(low_angle_q);
      step   = (step_q == '0) ? 1 : int'(step_q);
      quot   = offset / step;
      rem    = offset % step;
      if (quot >= DEPTH) begin
        r.err = ERR_DEPTH;
      end else if (rem == 0) begin
        r.value = sample_mirror[quot];
      end else if (quot + 1 >= DEPTH) begin
        r.err = ERR_DEPTH;
      end else begin
        lower   = int'(sample_mirror[quot]);
        upper   = int'(sample_mirror[quot + 1]);
        r.value = SAMPLE_W'(lower + ((upper - lower) * rem) / step);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_angle_q  = LOW_ANGLE_RST;
      high_angle_q = HIGH_ANGLE_RST;
      step_q       = STEP_SIZE_RST;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[ADDR_W-1:2]))
          REG_LOW_ANGLE:  low_angle_q  = pwdata_i[ANGLE_W-1:0];
          REG_HIGH_ANGLE: high_angle_q = pwdata_i[ANGLE_W-1:0];
          REG_STEP_SIZE:  step_q       = pwdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: value %0d, range_error %0d",
                   $time, value_i, range_error_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (value_i !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, want.value, value_i);
            fails++;
          end
          if (range_error_i !== want.err) begin
            $display("%0t: range_error mismatch: expected %0d, actual %0d",
                     $time, want.err, range_error_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (action_e'(action_i) == ACT_EVAL) begin
          expected_results.push_back(interpolate_angle(angle_i));
        end else if (int'(entry_index_i) < DEPTH) begin
          sample_mirror[entry_index_i] = entry_value_i;
        end
      end
      pending_o <= expected_results.size();
    end
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb_table_interpolated_sine_top.sv =====
// Testbench top for the table interpolated sine evaluator: stimulus, config writes, verdict.
module tb_table_interpolated_sine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tis_pkg::*;

  localparam int LATENCY_WAIT    = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 125;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       start         = 1'b0;
  logic                       busy;
  logic                       action_i      = 1'b0;
  logic signed [ANGLE_W-1:0]  angle_i       = '0;
  logic [IDX_W-1:0]           entry_index_i = '0;
  logic signed [SAMPLE_W-1:0] entry_value_i = '0;
  logic                       result_valid_o;
  logic signed [SAMPLE_W-1:0] value_o;
  logic [1:0]                 range_error_o;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [ADDR_W-1:0]          paddr         = '0;
  logic [DATA_W-1:0]          pwdata        = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  int                         fail_count;
  int                         pending;
  int                         cycle_count   = 0;
  int                         burst_left    = 0;

  table_interpolated_sine_top i_dut (.*);

  table_interpolated_sine_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action_i),
    .angle_i        (angle_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .result_valid_i (result_valid_o),
    .value_i        (value_o),
    .range_error_i  (range_error_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rand_angle();
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0:       return 32767;
      1:       return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // one transaction; sender gaps fall between bursts
  task automatic issue(action_e act, int angle, int idx, int value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    start         <= 1'b1;
    action_i      <= act;
    angle_i       <= ANGLE_W'(angle);
    entry_index_i <= IDX_W'(idx);
    entry_value_i <= SAMPLE_W'(value);
    @(posedge clk_i iff !busy);
    burst_left--;
  endtask

  task automatic eval_angle(int angle);
    issue(ACT_EVAL, angle, $urandom_range(0, 31), int'($urandom_range(0, 65535)));
  endtask

  task automatic write_entry(int idx, int value);
    issue(ACT_WRITE, rand_angle(), idx, value);
  endtask

  task automatic load_table();
    for (int i = 0; i < DEFAULT_TABLE_DEPTH; i++) begin
      write_entry(i, rand_sample());
    end
  endtask

  // stop sending, wait for the last result and for trailing writes to clear the pipe
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i iff pending == 0);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_write(cfg_reg_e r, int val, int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({r, 2'b00});
    pwdata  <= DATA_W'(($urandom << width) | (val & ((1 << width) - 1)));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_range(int lo, int hi, int step);
    settle();
    apb_write(REG_LOW_ANGLE, lo, ANGLE_W);
    apb_write(REG_HIGH_ANGLE, hi, ANGLE_W);
    apb_write(REG_STEP_SIZE, step, STEP_W);
  endtask

  initial begin
    int lo, hi, st;
    int reset_angles [] = '{-512, 511, -1, 91, 0, 90, 7, 8, 89};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: low 0, high 90, step 5
    load_table();
    write_entry(1, 32767);
    write_entry(2, -32768);
    foreach (reset_angles[i]) eval_angle(reset_angles[i]);

    // last entry hit, inexact hit past the end, quotient past the end
    set_range(0, 511, 2);
    eval_angle(62);
    eval_angle(63);
    eval_angle(64);
    eval_angle(511);

    // zero step behaves as one
    set_range(0, 100, 0);
    eval_angle(5);
    eval_angle(31);
    eval_angle(32);

    // low above high
    set_range(10, -10, 5);
    eval_angle(0);
    eval_angle(20);
    eval_angle(-20);

    set_range(-512, 511, 511);
    eval_angle(-512);
    eval_angle(-1);
    eval_angle(0);
    eval_angle(511);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lo = -512; hi = 511; st = 33;  end
        1: begin lo = 511;  hi = 511; st = 1;   end
        2: begin lo = -360; hi = 360; st = 360; end
        default: begin
          lo = rand_angle();
          hi = ($urandom_range(0, 4) == 0) ? rand_angle() : lo + $urandom_range(0, 511 - lo);
          if (hi > lo && $urandom_range(0, 9) < 6) st = (hi - lo + 30) / 31;
          else if ($urandom_range(0, 1) == 0)      st = $urandom_range(1, 8);
          else                                     st = $urandom_range(0, 511);
        end
      endcase
      set_range(lo, hi, st);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 199) == 0) load_table();
        if ($urandom_range(0, 3) == 0)                    write_entry($urandom_range(0, 31), rand_sample());
        else if (lo <= hi && $urandom_range(0, 9) < 8)    eval_angle(lo + $urandom_range(0, hi - lo));
        else                                              eval_angle(rand_angle());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
